### sv/lcfs_pkg.sv
// Shared types and constants for the LED cube frame store and layer scanner.
// Holds the operation codes, the command word passed from front to back and queue sizing.
// No dependencies.
`default_nettype none

package lcfs_pkg;

    localparam int CUBE_SIZE_DEFAULT = 8;

    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int ROWS        = 8;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int STORE_DEPTH = ROWS * ROWS;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    typedef enum logic [1:0] {
        CMD_SET  = 2'd0,
        CMD_READ = 2'd1,
        CMD_TICK = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [IDX_W-1:0]  row_idx;
        logic [ROW_W-1:0]  bit_sel;
        logic              led_on;
        logic              hit;
    } cmd_t;

endpackage

`default_nettype wire

### sv/lcfs_front.sv
// Front end: accepts operations, checks coordinates and builds command words.
// Depends on lcfs_pkg.
`default_nettype none

module lcfs_front #(
    parameter int CUBE_SIZE = lcfs_pkg::CUBE_SIZE_DEFAULT
) (
    input  wire logic           start,
    input  wire logic [1:0]     op,
    input  wire logic [7:0]     x_coord,
    input  wire logic [7:0]     y_coord,
    input  wire logic [7:0]     z_coord,
    input  wire logic           led_on,
    input  wire logic           q_full,
    output lcfs_pkg::cmd_t      cmd,
    output logic                push
);
    import lcfs_pkg::*;

    localparam logic [7:0] Limit = 8'(CUBE_SIZE);

    logic accept;
    logic in_range;

    assign accept   = start && !q_full;
    assign in_range = (x_coord < Limit) && (y_coord < Limit) && (z_coord < Limit);

    always_comb
    begin
        cmd.row_idx = {z_coord[ROW_W-1:0], ROW_W'(ROWS - 1) - x_coord[ROW_W-1:0]};
        cmd.bit_sel = y_coord[ROW_W-1:0];
        cmd.led_on  = led_on;
        cmd.hit     = in_range;
        cmd.kind    = CMD_TICK;
        push        = 1'b0;
        unique case (op)
            OP_SET:
            begin
                cmd.kind = CMD_SET;
                push     = accept && in_range;
            end
            OP_READ:
            begin
                cmd.kind = CMD_READ;
                push     = accept;
            end
            OP_TICK:
            begin
                cmd.kind = CMD_TICK;
                push     = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/lcfs_queue.sv
// Short command queue between the front end and the back end.
// Depends on lcfs_pkg.
`default_nettype none

module lcfs_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lcfs_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output lcfs_pkg::cmd_t      head,
    output logic                full,
    output logic                empty
);
    import lcfs_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if ((push && !full) && !(pop && !empty))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### sv/lcfs_back.sv
// Back end: frame store memory, voxel update and read, and the layer scan sequencer.
// Depends on lcfs_pkg; takes commands from lcfs_queue.
`default_nettype none

module lcfs_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lcfs_pkg::cmd_t head,
    input  wire logic           empty,
    output logic                pop,
    output logic                result_valid,
    output logic                voxel_state,
    output logic [7:0]          column_byte,
    output logic [2:0]          latch_address,
    output logic [7:0]          layer_enable,
    output logic                last
);
    import lcfs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_SET_WR   = 4'b0010,
        ST_READ_OUT = 4'b0100,
        ST_TICK     = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [ROW_W-1:0]   layer_reg, layer_next;

    logic [7:0]             mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] vld_reg;
    logic [7:0]             rd_data_reg;
    logic                   rd_vld_reg;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [7:0]         wr_data;
    logic [7:0]         cur_byte;
    logic [7:0]         bit_mask;

    logic               res_valid_reg, res_valid_next;
    logic               res_voxel_reg, res_voxel_next;
    logic [7:0]         res_col_reg, res_col_next;
    logic [2:0]         res_addr_reg, res_addr_next;
    logic [7:0]         res_en_reg, res_en_next;
    logic               res_last_reg, res_last_next;

    assign cur_byte = rd_vld_reg ? rd_data_reg : 8'd0;
    assign bit_mask = 8'd1 << cmd_reg.bit_sel;
    assign wr_data  = (cur_byte & ~bit_mask) | (cmd_reg.led_on ? bit_mask : 8'd0);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        row_next       = row_reg;
        layer_next     = layer_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = cmd_reg.row_idx;
        wr_en          = 1'b0;
        res_valid_next = 1'b0;
        res_voxel_next = 1'b0;
        res_col_next   = 8'd0;
        res_addr_next  = 3'd0;
        res_en_next    = 8'd0;
        res_last_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    rd_en    = 1'b1;
                    rd_addr  = head.row_idx;
                    unique case (head.kind)
                        CMD_SET:  state_next = ST_SET_WR;
                        CMD_READ: state_next = ST_READ_OUT;
                        CMD_TICK:
                        begin
                            rd_addr    = {layer_reg, ROW_W'(0)};
                            row_next   = '0;
                            state_next = ST_TICK;
                        end
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SET_WR:
            begin
                wr_en      = 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ_OUT:
            begin
                res_valid_next = 1'b1;
                res_voxel_next = cmd_reg.hit && cur_byte[cmd_reg.bit_sel];
                res_last_next  = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_TICK:
            begin
                res_valid_next = 1'b1;
                res_col_next   = cur_byte;
                res_addr_next  = 3'(row_reg + 1'b1);
                if (row_reg == ROW_W'(ROWS - 1))
                begin
                    res_last_next = 1'b1;
                    res_en_next   = 8'd1 << layer_reg;
                    layer_next    = layer_reg + 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = {layer_reg, row_reg + 1'b1};
                    row_next = row_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            layer_reg     <= '0;
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_voxel_reg <= 1'b0;
            res_col_reg   <= 8'd0;
            res_addr_reg  <= 3'd0;
            res_en_reg    <= 8'd0;
            res_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            layer_reg     <= layer_next;
            res_valid_reg <= res_valid_next;
            res_voxel_reg <= res_voxel_next;
            res_col_reg   <= res_col_next;
            res_addr_reg  <= res_addr_next;
            res_en_reg    <= res_en_next;
            res_last_reg  <= res_last_next;
            if (wr_en)
            begin
                vld_reg[cmd_reg.row_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (wr_en)
        begin
            mem[cmd_reg.row_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign result_valid  = res_valid_reg;
    assign voxel_state   = res_voxel_reg;
    assign column_byte   = res_col_reg;
    assign latch_address = res_addr_reg;
    assign layer_enable  = res_en_reg;
    assign last          = res_last_reg;

endmodule

`default_nettype wire

### sv/led_cube_frame_store_and_layer_scan.sv
// Top level of the LED cube frame store and layer scanner.
// Depends on lcfs_pkg, lcfs_front, lcfs_queue and lcfs_back.
//
// An operation is taken when start is high and busy is low; busy rises only while the
// two-entry command queue is full. A taken command is registered in a queue entry before it
// can leave the queue. A voxel set then reads the row byte as the command leaves the queue
// and writes it back, modified, in the next cycle; a read registers the row byte as it leaves
// the queue and then puts its single result on the ports from the result registers; and a
// refresh tick gives eight results on consecutive cycles, one per row read from the frame
// store, each row byte and each result being registered on its way. Each result is shown
// for one cycle with result_valid high and must be taken then, as the block cannot be held off.
// The frame store reads as all zero after reset without any clearing pass, so operations may
// start in the first cycle after reset.
`default_nettype none

module led_cube_frame_store_and_layer_scan #(
    parameter int CUBE_SIZE = lcfs_pkg::CUBE_SIZE_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  x_coord,
    input  wire logic [7:0]  y_coord,
    input  wire logic [7:0]  z_coord,
    input  wire logic        led_on,
    output logic             result_valid,
    output logic             voxel_state,
    output logic [7:0]       column_byte,
    output logic [2:0]       latch_address,
    output logic [7:0]       layer_enable,
    output logic             last
);
    import lcfs_pkg::*;

    cmd_t front_cmd;
    cmd_t q_head;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    lcfs_front #(
        .CUBE_SIZE(CUBE_SIZE)
    ) u_front (
        .start   (start),
        .op      (op),
        .x_coord (x_coord),
        .y_coord (y_coord),
        .z_coord (z_coord),
        .led_on  (led_on),
        .q_full  (q_full),
        .cmd     (front_cmd),
        .push    (push)
    );

    lcfs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    lcfs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .empty         (q_empty),
        .pop           (pop),
        .result_valid  (result_valid),
        .voxel_state   (voxel_state),
        .column_byte   (column_byte),
        .latch_address (latch_address),
        .layer_enable  (layer_enable),
        .last          (last)
    );

    assign busy = q_full;

    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(layer_enable))
        else $error("layer enable drives more than one layer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (layer_enable != 8'd0) |-> (result_valid && last && latch_address == 3'd0))
        else $error("layer enable outside the final scan result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && voxel_state) |-> (last && column_byte == 8'd0))
        else $error("voxel state set on a scan result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |=> result_valid)
        else $error("scan results not on consecutive cycles");

endmodule

`default_nettype wire

### dv/led_cube_frame_store_and_layer_scan_tb.sv
// Self-checking testbench for the LED cube frame store and layer scanner.
// Drives voxel set, voxel read, refresh tick and unused operation code transactions and checks every result
// against a voxel frame predictor. Depends on lcfs_pkg and led_cube_frame_store_and_layer_scan.
`default_nettype none

module led_cube_frame_store_and_layer_scan_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lcfs_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 325;

    typedef struct {
        logic       voxel_state;
        logic [7:0] column_byte;
        logic [2:0] latch_address;
        logic [7:0] layer_enable;
        logic       last;
    } cube_result_t;

    class voxel_frame_predictor;
        logic [7:0]   row_bytes [64];
        logic [2:0]   scan_layer;
        cube_result_t expected_results [$];
        int           errors;

        function new();
            foreach (row_bytes[i])
            begin
                row_bytes[i] = 8'h00;
            end
            scan_layer = 3'd0;
            errors = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_command(logic [1:0] op, logic [7:0] x, logic [7:0] y,
                                   logic [7:0] z, logic on);
            cube_result_t r;
            logic         in_range;
            logic [5:0]   row_idx;
            in_range = (x < 8) && (y < 8) && (z < 8);
            row_idx = {z[2:0], 3'd7 - x[2:0]};
            r = '{1'b0, 8'h00, 3'd0, 8'h00, 1'b0};
            case (op)
                OP_SET:
                begin
                    if (in_range)
                    begin
                        row_bytes[row_idx][y[2:0]] = on;
                    end
                end
                OP_READ:
                begin
                    r.voxel_state = in_range ? row_bytes[row_idx][y[2:0]] : 1'b0;
                    r.last = 1'b1;
                    expected_results.push_back(r);
                end
                OP_TICK:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        r.column_byte = row_bytes[{scan_layer, 3'(i)}];
                        r.latch_address = 3'(i + 1);
                        r.last = (i == 7);
                        r.layer_enable = (i == 7) ? (8'h01 << scan_layer) : 8'h00;
                        expected_results.push_back(r);
                    end
                    scan_layer = scan_layer + 3'd1;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(string field, int unsigned exp, int unsigned act);
            if (exp != act)
            begin
                $error("%s mismatch: expected %0d, got %0d", field, exp, act);
                errors++;
            end
        endfunction

        function void check_result(cube_result_t act);
            cube_result_t exp;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: column_byte %0d, latch_address %0d",
                       act.column_byte, act.latch_address);
                errors++;
                return;
            end
            exp = expected_results.pop_front();
            compare_field("voxel_state", exp.voxel_state, act.voxel_state);
            compare_field("column_byte", exp.column_byte, act.column_byte);
            compare_field("latch_address", exp.latch_address, act.latch_address);
            compare_field("layer_enable", exp.layer_enable, act.layer_enable);
            compare_field("last", exp.last, act.last);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] op;
    logic [7:0] x_coord;
    logic [7:0] y_coord;
    logic [7:0] z_coord;
    logic       led_on;
    logic       result_valid;
    logic       voxel_state;
    logic [7:0] column_byte;
    logic [2:0] latch_address;
    logic [7:0] layer_enable;
    logic       last;

    voxel_frame_predictor frame_model;

    led_cube_frame_store_and_layer_scan dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .z_coord       (z_coord),
        .led_on        (led_on),
        .result_valid  (result_valid),
        .voxel_state   (voxel_state),
        .column_byte   (column_byte),
        .latch_address (latch_address),
        .layer_enable  (layer_enable),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            frame_model.check_result('{voxel_state, column_byte, latch_address,
                                       layer_enable, last});
        end
    end

    task automatic issue(logic [1:0] code, logic [7:0] x, logic [7:0] y, logic [7:0] z,
                         logic on);
        @(negedge clk);
        start = 1'b1;
        op = code;
        x_coord = x;
        y_coord = y;
        z_coord = z;
        led_on = on;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        frame_model.note_command(code, x, y, z, on);
    endtask

    task automatic pause(int unsigned cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start = 1'b0;
            x_coord = 8'($urandom);
        end
    endtask

    function automatic logic [7:0] random_coord();
        if ($urandom_range(0, 6) != 0)
        begin
            return 8'($urandom_range(0, 7));
        end
        return 8'($urandom_range(8, 255));
    endfunction

    task automatic random_transaction(output bit counted);
        int unsigned pick;
        logic [1:0]  code;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            code = OP_SET;
        end
        else if (pick < 75)
        begin
            code = OP_READ;
        end
        else if (pick < 96)
        begin
            code = OP_TICK;
        end
        else
        begin
            code = OP_UNUSED;
        end
        issue(code, random_coord(), random_coord(), random_coord(), 1'($urandom));
        counted = (code != OP_UNUSED);
    endtask

    initial
    begin
        int unsigned issued;
        int unsigned burst_len;
        bit          counted;
        frame_model = new();
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_SET;
        x_coord = 8'd0;
        y_coord = 8'd0;
        z_coord = 8'd0;
        led_on = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        issue(OP_SET, 8'd0, 8'd0, 8'd0, 1'b1);
        issue(OP_SET, 8'd7, 8'd7, 8'd7, 1'b1);
        issue(OP_SET, 8'd7, 8'd0, 8'd0, 1'b1);
        issue(OP_SET, 8'd0, 8'd7, 8'd7, 1'b1);
        issue(OP_SET, 8'd8, 8'd3, 8'd2, 1'b1);
        issue(OP_SET, 8'd7, 8'd7, 8'd7, 1'b0);
        issue(OP_READ, 8'd0, 8'd0, 8'd0, 1'b0);
        issue(OP_READ, 8'd7, 8'd7, 8'd7, 1'b1);
        issue(OP_READ, 8'd0, 8'd3, 8'd2, 1'b0);
        issue(OP_READ, 8'd8, 8'd0, 8'd0, 1'b1);
        issue(OP_READ, 8'd255, 8'd255, 8'd255, 1'b0);
        issue(OP_READ, 8'd0, 8'd7, 8'd7, 1'b0);
        issue(OP_UNUSED, 8'd0, 8'd0, 8'd0, 1'b1);
        repeat (9)
        begin
            issue(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
        end
        pause(4);

        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            burst_len = $urandom_range(1, 24);
            repeat (burst_len)
            begin
                random_transaction(counted);
                if (counted)
                begin
                    issued++;
                end
            end
            if ($urandom_range(0, 3) != 0)
            begin
                pause($urandom_range(1, 12));
            end
        end

        pause(1);
        while (frame_model.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (frame_model.errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
